@@ sv/lpr_pkg.sv @@
// lpr_pkg: shared types and constants of the line pixel rasterizer
// beat structs for both channels, the walker state struct and the action codes
// no dependencies
package lpr_pkg;

    // coordinate width, fixed by the beat formats
    localparam int COORD_BITS = 9;
    // error term carries sign plus one bit of headroom over a coordinate
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 16;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    // input beat
    typedef struct packed {
        logic   action;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        color_t line_color;
    } in_beat_t;

    // result beat
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last;
        logic   valid_res;
    } out_beat_t;

    // walker state kept between beats
    typedef struct packed {
        coord_t                     cursor_x;
        coord_t                     cursor_y;
        logic signed [ERR_BITS-1:0] error_term;
        coord_t                     delta_major;
        coord_t                     delta_minor;
        logic [COORD_BITS:0]        pixels_left;
        logic                       x_is_major;
        logic                       x_goes_down;
        logic                       y_goes_down;
        color_t                     held_color;
        logic                       line_active;
    } lpr_state_t;

endpackage

@@ sv/line_pixel_rasterizer.sv @@
// line_pixel_rasterizer: eight-octant bresenham line walker, one pixel per beat
// input register, walker state and result register around lpr_step
// depends on lpr_pkg and lpr_step
//
//   channel  direction  payload     handshake
//   s_       in         in_beat_t   s_valid / s_ready
//   m_       out        out_beat_t  m_valid / m_ready
//
// every input beat gives exactly one result beat, via input and result registers
// a new beat is accepted every cycle unless m_ stalls; the walker state loop closes
// through lpr_step, from the input register to the state and result registers
// aresetn clears both valid flags and the walker state (no line active)
// a stalled result holds in the result register while one more input beat waits
// in the input register; s_ready drops only when both are full
module line_pixel_rasterizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lpr_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lpr_pkg::out_beat_t  m_data
);
    import lpr_pkg::*;

    logic       in_valid_reg;
    in_beat_t   in_beat_reg;
    logic       out_valid_reg;
    out_beat_t  out_beat_reg;
    lpr_state_t state_reg;
    lpr_state_t state_next;
    out_beat_t  result;
    logic       out_free;
    logic       step_go;

    // handshake between the two register stages
    assign out_free = !out_valid_reg || m_ready;
    assign step_go  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step_go;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_beat_reg;

    lpr_step u_step (
        .beat       (in_beat_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    // walker state, advanced once per processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step_go) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step_go) begin
            out_beat_reg <= result;
        end
    end

endmodule

@@ sv/lpr_step.sv @@
// lpr_step: one walker step, pure combinational
// loads a line or takes the held one, forms the pixel and the next walker state
// depends on lpr_pkg
module lpr_step (
    input  lpr_pkg::in_beat_t   beat,
    input  lpr_pkg::lpr_state_t state_cur,
    output lpr_pkg::lpr_state_t state_next,
    output lpr_pkg::out_beat_t  result
);
    import lpr_pkg::*;

    logic                       x_down;
    logic                       y_down;
    coord_t                     dx;
    coord_t                     dy;
    logic                       x_major;
    coord_t                     maj_ld;
    coord_t                     min_ld;
    logic signed [ERR_BITS-1:0] err_ld;
    lpr_state_t                 cur;
    logic                       minor_step;
    logic signed [ERR_BITS-1:0] err_adv;
    logic                       end_of_line;

    // wrapping one-pixel step toward the end point
    function automatic coord_t step_coord(input coord_t c, input logic down);
        step_coord = down ? (c - coord_t'(1)) : (c + coord_t'(1));
    endfunction

    // line setup: deltas, directions, major axis, starting error
    always_comb begin
        x_down  = (beat.x_end < beat.x_start);
        y_down  = (beat.y_end < beat.y_start);
        dx      = x_down ? (beat.x_start - beat.x_end) : (beat.x_end - beat.x_start);
        dy      = y_down ? (beat.y_start - beat.y_end) : (beat.y_end - beat.y_start);
        x_major = (dx >= dy);
        maj_ld  = x_major ? dx : dy;
        min_ld  = x_major ? dy : dx;
        err_ld  = $signed({2'b00, min_ld}) - $signed({3'b000, maj_ld[COORD_BITS-1:1]});
    end

    // state seen by this beat: freshly loaded line or the one held
    always_comb begin
        cur = state_cur;
        if (beat.action == ACT_LOAD) begin
            cur.cursor_x    = beat.x_start;
            cur.cursor_y    = beat.y_start;
            cur.error_term  = err_ld;
            cur.delta_major = maj_ld;
            cur.delta_minor = min_ld;
            // count left after this pixel goes out
            cur.pixels_left = {1'b0, maj_ld};
            cur.x_is_major  = x_major;
            cur.x_goes_down = x_down;
            cur.y_goes_down = y_down;
            cur.held_color  = beat.line_color;
            cur.line_active = 1'b1;
        end else begin
            cur.pixels_left = state_cur.pixels_left - (COORD_BITS+1)'(1);
        end
    end

    // pixel output and bresenham advance
    always_comb begin
        minor_step  = !cur.error_term[ERR_BITS-1] && (cur.error_term != '0);
        err_adv     = cur.error_term
                    - (minor_step ? $signed({2'b00, cur.delta_major}) : '0)
                    + $signed({2'b00, cur.delta_minor});
        end_of_line = (cur.pixels_left == '0);

        result     = '0;
        state_next = state_cur;
        if (cur.line_active) begin
            result.pixel_x     = cur.cursor_x;
            result.pixel_y     = cur.cursor_y;
            result.pixel_color = cur.held_color;
            result.last        = end_of_line;
            result.valid_res   = 1'b1;

            state_next = cur;
            if (end_of_line) begin
                state_next.line_active = 1'b0;
            end else begin
                state_next.error_term = err_adv;
                if (cur.x_is_major) begin
                    state_next.cursor_x = step_coord(cur.cursor_x, cur.x_goes_down);
                    if (minor_step) begin
                        state_next.cursor_y = step_coord(cur.cursor_y, cur.y_goes_down);
                    end
                end else begin
                    state_next.cursor_y = step_coord(cur.cursor_y, cur.y_goes_down);
                    if (minor_step) begin
                        state_next.cursor_x = step_coord(cur.cursor_x, cur.x_goes_down);
                    end
                end
            end
        end
    end

endmodule

@@ sv/lpr_checker.sv @@
// lpr_checker: port-level assertions for line_pixel_rasterizer, bound to the top
// watches reset, result stall behavior, input blocking, idle-pixel encoding and the last flag
// depends on lpr_pkg
module lpr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input lpr_pkg::out_beat_t m_data
);
    import lpr_pkg::*;

    // no result right after a reset cycle
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // a draining output never blocks the input side
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // a request with no line gives an all-zero result
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |->
            (m_data.pixel_x == '0) && (m_data.pixel_y == '0) &&
            (m_data.pixel_color == '0) && !m_data.last)
        else $error("idle result carries data");

    // the last flag only rides on a real pixel
    a_last_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.valid_res)
        else $error("last flag on empty result");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);

@@ bench/line_pixel_rasterizer_test.sv @@
// line_pixel_rasterizer_test: self-checking bench for the eight-octant line walker
// holds a pixel scoreboard class with its own walker copy, plus driver and receiver processes
// depends on lpr_pkg and the line_pixel_rasterizer rtl
`timescale 1ns / 100ps

module line_pixel_rasterizer_test;
    import lpr_pkg::*;

    // walker copy and queue of pixels still owed by the block
    class pixel_scoreboard;
        coord_t    cur_x;
        coord_t    cur_y;
        color_t    color;
        int        err;
        int        major;
        int        minor;
        int        left;
        bit        x_major;
        bit        x_down;
        bit        y_down;
        bit        active;
        int        mismatches;
        out_beat_t expected_pixels[$];

        function coord_t step_coord(coord_t c, bit down);
            return down ? coord_t'(c - 1) : coord_t'(c + 1);
        endfunction

        // predict the pixel caused by one accepted input beat
        function void note_beat(in_beat_t b);
            out_beat_t px;
            int        dx;
            int        dy;
            if (b.action == ACT_LOAD) begin
                x_down  = b.x_end < b.x_start;
                y_down  = b.y_end < b.y_start;
                dx      = x_down ? int'(b.x_start) - int'(b.x_end)
                                 : int'(b.x_end) - int'(b.x_start);
                dy      = y_down ? int'(b.y_start) - int'(b.y_end)
                                 : int'(b.y_end) - int'(b.y_start);
                x_major = dx >= dy;
                major   = x_major ? dx : dy;
                minor   = x_major ? dy : dx;
                err     = minor - major / 2;
                cur_x   = b.x_start;
                cur_y   = b.y_start;
                color   = b.line_color;
                left    = major + 1;
                active  = 1'b1;
            end
            px = '0;
            if (active) begin
                px.pixel_x     = cur_x;
                px.pixel_y     = cur_y;
                px.pixel_color = color;
                left--;
                px.last        = (left == 0);
                px.valid_res   = 1'b1;
                if (left == 0) begin
                    active = 1'b0;
                end else begin
                    // minor step first when the error is positive, then the major step
                    if (err > 0) begin
                        if (x_major) cur_y = step_coord(cur_y, y_down);
                        else         cur_x = step_coord(cur_x, x_down);
                        err -= major;
                    end
                    if (x_major) cur_x = step_coord(cur_x, x_down);
                    else         cur_y = step_coord(cur_y, y_down);
                    err += minor;
                end
            end
            expected_pixels.push_back(px);
        endfunction

        // compare one result beat against the oldest prediction
        function void check_pixel(out_beat_t got);
            out_beat_t want;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: x=%0d y=%0d color=%h last=%b valid=%b",
                             got.pixel_x, got.pixel_y, got.pixel_color, got.last,
                             got.valid_res);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.pixel_color !== want.pixel_color || got.last !== want.last ||
                got.valid_res !== want.valid_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("pixel mismatch: expected x=%0d y=%0d color=%h last=%b valid=%b",
                             want.pixel_x, want.pixel_y, want.pixel_color, want.last,
                             want.valid_res);
                    $display("                got      x=%0d y=%0d color=%h last=%b valid=%b",
                             got.pixel_x, got.pixel_y, got.pixel_color, got.last,
                             got.valid_res);
                end
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    pixel_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;
    int beats_sent;

    line_pixel_rasterizer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result beats are checked as they are accepted
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_data);
    end

    // offer one input beat, idling first at random, and wait for acceptance
    task automatic send_beat(input in_beat_t b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(b);
        beats_sent++;
    endtask

    function automatic in_beat_t random_beat();
        in_beat_t b;
        b.action     = logic'($urandom_range(0, 1));
        b.x_start    = coord_t'($urandom_range(0, 511));
        b.y_start    = coord_t'($urandom_range(0, 511));
        b.x_end      = coord_t'($urandom_range(0, 511));
        b.y_end      = coord_t'($urandom_range(0, 511));
        b.line_color = color_t'($urandom_range(0, 65535));
        return b;
    endfunction

    task automatic load_line(input int xs, input int ys, input int xe, input int ye,
                             input int col);
        in_beat_t b;
        b.action     = ACT_LOAD;
        b.x_start    = coord_t'(xs);
        b.y_start    = coord_t'(ys);
        b.x_end      = coord_t'(xe);
        b.y_end      = coord_t'(ye);
        b.line_color = color_t'(col);
        send_beat(b);
    endtask

    // request pixels; coordinate and color fields carry random junk
    task automatic next_pixels(input int n);
        in_beat_t b;
        repeat (n) begin
            b        = random_beat();
            b.action = ACT_NEXT;
            send_beat(b);
        end
    endtask

    // endpoint a few steps away, kept inside the coordinate range
    function automatic int near_coord(input int c);
        int d;
        int v;
        d = int'($urandom_range(0, 14)) - 7;
        v = c + d;
        if (v < 0 || v > 511) v = c - d;
        return v;
    endfunction

    // mostly whole lines walked to the end, some abandoned, some overrun, some noise
    task automatic run_random(input int count);
        int stop_at;
        int xs;
        int ys;
        int xe;
        int ye;
        int dx;
        int dy;
        int n;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) send_beat(random_beat());
            end else begin
                xs = $urandom_range(0, 511);
                ys = $urandom_range(0, 511);
                if ($urandom_range(0, 15) == 0) begin
                    xe = $urandom_range(0, 511);
                    ye = $urandom_range(0, 511);
                end else begin
                    xe = near_coord(xs);
                    ye = near_coord(ys);
                end
                dx = (xe > xs) ? xe - xs : xs - xe;
                dy = (ye > ys) ? ye - ys : ys - ye;
                n  = (dx >= dy) ? dx : dy;
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(0, n);
                else if ($urandom_range(0, 3) == 0)
                    n = n + $urandom_range(1, 2);
                if (n > 40 && $urandom_range(0, 3) != 0)
                    n = $urandom_range(0, 40);
                load_line(xs, ys, xe, ye, $urandom_range(0, 65535));
                next_pixels(n);
            end
        end
    endtask

    initial begin
        sb           = new();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        hold_left    = 0;
        beats_sent   = 0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // request with no line active gives an empty result
        next_pixels(1);
        // single-point lines at both corners, with a request after the first line ended
        load_line(0, 0, 0, 0, 16'h0000);
        next_pixels(1);
        load_line(511, 511, 511, 511, 16'hffff);
        // long diagonal abandoned by a new load while active
        load_line(0, 0, 511, 511, 16'ha5a5);
        next_pixels(3);
        load_line(511, 0, 0, 511, 16'h5a5a);
        next_pixels(2);
        // decreasing walks that end on coordinate zero, one overrun request
        load_line(5, 3, 0, 0, 16'hf800);
        next_pixels(6);
        load_line(0, 6, 2, 0, 16'h07e0);
        next_pixels(6);
        // tie between the axes picks x as major
        load_line(3, 0, 0, 3, 16'h001f);
        next_pixels(3);

        // no idling, with a long receiver hold-off so the input backs up
        hold_request = 300;
        run_random(230);
        idle_pct  = 87;
        stall_pct = 0;
        run_random(230);
        idle_pct  = 0;
        stall_pct = 87;
        run_random(230);
        idle_pct  = 28;
        stall_pct = 28;
        run_random(230);

        // drain
        @(negedge aclk);
        s_valid   <= 1'b0;
        stall_pct = 0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("line_pixel_rasterizer test passed");
        end else begin
            $display("line_pixel_rasterizer test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("line_pixel_rasterizer test failed");
        $finish;
    end

endmodule
